// ===== hdl/ceod_pkg.sv =====
`default_nettype none
// ============================================================================
// ceod_pkg - shared types and constants for the colour edge outline block
// Line buffer geometry, register indexes, configuration and queue entry types.
// ============================================================================
package ceod_pkg;

	// line buffer geometry
	localparam int MAX_WIDTH = 2048;
	localparam int AW        = $clog2(MAX_WIDTH);
	localparam int DIM_W     = 12;

	// front/back queue
	localparam int QDEPTH = 4;
	localparam int QAW    = $clog2(QDEPTH);

	// stream widths
	localparam int IN_TDATA_W  = 32;
	localparam int OUT_TDATA_W = 56;

	// darkening limits
	localparam logic [8:0] STRENGTH_MAX = 9'd218;
	localparam logic [8:0] STRENGTH_OFF = 9'd2;

	// register indexes
	localparam logic [2:0] REG_FRAME_WIDTH    = 3'd0;
	localparam logic [2:0] REG_FRAME_HEIGHT   = 3'd1;
	localparam logic [2:0] REG_STRENGTH_Q8    = 3'd2;
	localparam logic [2:0] REG_EDGE_THRESHOLD = 3'd3;
	localparam logic [2:0] REG_PIXEL_ORDER    = 3'd4;

	typedef struct packed {
		logic [DIM_W-1:0] frame_width;
		logic [DIM_W-1:0] frame_height;
		logic [8:0]       strength_q8;
		logic [10:0]      edge_threshold;
	} cfg_t;

	// per-item control from the front
	typedef struct packed {
		logic [AW-1:0]    x;
		logic [DIM_W-1:0] y;
		logic             has_center;
		logic             has_self;
		logic             interior;
		logic             last;
	} ctl_t;

	// neighbourhood read from the line buffers
	typedef struct packed {
		logic [31:0] center;
		logic [31:0] right;
		logic [31:0] up;
		logic [31:0] down;
	} win_t;

	// one queued item: up to two results
	typedef struct packed {
		logic [31:0]      center_pix;
		logic [31:0]      self_pix;
		logic [AW-1:0]    x;
		logic [DIM_W-1:0] y;
		logic             has_center;
		logic             has_self;
		logic             last;
	} entry_t;

endpackage
`default_nettype wire

// ===== hdl/ceod_front.sv =====
`default_nettype none
// ============================================================================
// ceod_front - position tracking and line buffers
// Accepts pixels, classifies their position and reads the cross neighbourhood
// from the two line buffers into the first pipeline stage.
// ============================================================================
module ceod_front import ceod_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire cfg_t        cfg,
	input  wire logic        accept,
	input  wire logic [31:0] in_pixel,
	input  wire logic        frame_start,
	output logic             valid_s1,
	output win_t             win_s1,
	output ctl_t             ctl_s1
);

	logic [AW-1:0]    col_q;
	logic [DIM_W-1:0] row_q;

	logic [DIM_W-1:0] w_eff, h_eff;
	logic             wrap, last_col, last_row, enabled;
	logic [AW-1:0]    x_cur;
	logic [DIM_W-1:0] x_p1, y_cur;

	logic [31:0] center_mem [MAX_WIDTH];
	logic [31:0] above_mem  [MAX_WIDTH];

	// effective frame size and current position
	always_comb begin
		if (cfg.frame_width == '0)
			w_eff = DIM_W'(1);
		else if (cfg.frame_width > DIM_W'(MAX_WIDTH))
			w_eff = DIM_W'(MAX_WIDTH);
		else
			w_eff = cfg.frame_width;
		h_eff = (cfg.frame_height == '0) ? DIM_W'(1) : cfg.frame_height;
		wrap = frame_start || (DIM_W'(col_q) >= w_eff) || (row_q >= h_eff);
		x_cur = wrap ? '0 : col_q;
		y_cur = wrap ? '0 : row_q;
		x_p1 = DIM_W'(x_cur) + DIM_W'(1);
		last_col = x_p1 >= w_eff;
		last_row = (y_cur + DIM_W'(1)) >= h_eff;
		enabled = (cfg.strength_q8 > STRENGTH_OFF) && (w_eff >= DIM_W'(3))
			&& (h_eff >= DIM_W'(3));
	end

	// position counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			if (last_col) begin
				col_q <= '0;
				row_q <= last_row ? '0 : y_cur + DIM_W'(1);
			end else begin
				col_q <= x_p1[AW-1:0];
				row_q <= y_cur;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else
			valid_s1 <= accept;
	end

	// line buffers: centre row written on accept, row above in the cycle after
	always_ff @(posedge clk) begin
		if (accept) begin
			center_mem[x_cur] <= in_pixel;
			win_s1.center     <= center_mem[x_cur];
			win_s1.right      <= center_mem[x_p1[AW-1:0]];
			win_s1.up         <= (valid_s1 && ctl_s1.x == x_cur) ? win_s1.center
				: above_mem[x_cur];
			win_s1.down       <= in_pixel;
		end
		if (valid_s1)
			above_mem[ctl_s1.x] <= win_s1.center;
	end

	// classification of the item
	always_ff @(posedge clk) begin
		if (accept) begin
			ctl_s1.x          <= x_cur;
			ctl_s1.y          <= y_cur;
			ctl_s1.has_center <= y_cur != '0;
			ctl_s1.has_self   <= last_row;
			ctl_s1.interior   <= enabled && (y_cur >= DIM_W'(2)) && (x_cur != '0)
				&& (x_p1 < w_eff);
			ctl_s1.last       <= last_row && last_col;
		end
	end

endmodule
`default_nettype wire

// ===== hdl/ceod_edge.sv =====
`default_nettype none
// ============================================================================
// ceod_edge - edge test and darkening
// Sums the horizontal and vertical colour differences, then darkens the
// centre pixel on an edge and builds the queue entry.
// ============================================================================
module ceod_edge import ceod_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire cfg_t cfg,
	input  wire logic valid_s1,
	input  wire win_t win_s1,
	input  wire ctl_t ctl_s1,
	output logic      push,
	output entry_t    entry
);

	function automatic logic [9:0] sad(input logic [31:0] a, input logic [31:0] b);
		logic [9:0] acc;
		logic [7:0] ca, cb;
		acc = '0;
		for (int i = 0; i < 3; i++) begin
			ca = a[8*i +: 8];
			cb = b[8*i +: 8];
			acc = acc + 10'((ca > cb) ? ca - cb : cb - ca);
		end
		return acc;
	endfunction

	logic [31:0] left_q;
	logic        valid_s2;
	logic [10:0] hs_s2, vs_s2;
	logic [31:0] center_s2, down_s2;
	ctl_t        ctl_s2;

	logic [8:0]  strength, scale;
	logic [10:0] peak;
	logic        is_edge;
	logic [31:0] dark;
	logic [16:0] prod [3];

	// left neighbour is the centre of the previous item
	always_ff @(posedge clk) begin
		if (valid_s1)
			left_q <= win_s1.center;
	end

	// stage 2: direction sums
	always_ff @(posedge clk) begin
		if (valid_s1) begin
			hs_s2     <= 11'(sad(win_s1.center, left_q)) + 11'(sad(win_s1.center, win_s1.right));
			vs_s2     <= 11'(sad(win_s1.center, win_s1.up)) + 11'(sad(win_s1.center, win_s1.down));
			center_s2 <= win_s1.center;
			down_s2   <= win_s1.down;
			ctl_s2    <= ctl_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s2 <= 1'b0;
		else
			valid_s2 <= valid_s1;
	end

	// threshold and rounded per-channel scaling
	always_comb begin
		strength = (cfg.strength_q8 > STRENGTH_MAX) ? STRENGTH_MAX : cfg.strength_q8;
		scale = 9'd256 - strength;
		peak = (hs_s2 > vs_s2) ? hs_s2 : vs_s2;
		is_edge = ctl_s2.interior && (peak > cfg.edge_threshold);
		dark = 32'hFF00_0000;
		for (int i = 0; i < 3; i++) begin
			prod[i] = 17'(center_s2[8*i +: 8]) * 17'(scale) + 17'd128;
			dark[8*i +: 8] = prod[i][15:8];
		end
	end

	always_comb begin
		push             = valid_s2;
		entry.center_pix = is_edge ? dark : center_s2;
		entry.self_pix   = down_s2;
		entry.x          = ctl_s2.x;
		entry.y          = ctl_s2.y;
		entry.has_center = ctl_s2.has_center;
		entry.has_self   = ctl_s2.has_self;
		entry.last       = ctl_s2.last;
	end

endmodule
`default_nettype wire

// ===== hdl/ceod_queue.sv =====
`default_nettype none
// ============================================================================
// ceod_queue - short queue between front and back
// Holds classified items until the back end loads their last result for output.
// ============================================================================
module ceod_queue import ceod_pkg::*; (
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire logic   push,
	input  wire entry_t push_entry,
	input  wire logic   pop,
	output logic        head_valid,
	output entry_t      head,
	output logic [QAW:0] count
);

	entry_t         slots [QDEPTH];
	logic [QAW-1:0] wr_ptr_q, rd_ptr_q;

	always_ff @(posedge clk) begin
		if (push)
			slots[wr_ptr_q] <= push_entry;
	end

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count    <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + QAW'(1);
			if (pop)
				rd_ptr_q <= rd_ptr_q + QAW'(1);
			count <= count + (QAW+1)'(push) - (QAW+1)'(pop);
		end
	end

	assign head_valid = count != '0;
	assign head       = slots[rd_ptr_q];

endmodule
`default_nettype wire

// ===== hdl/ceod_back.sv =====
`default_nettype none
// ============================================================================
// ceod_back - result sequencer and output register
// Emits the centre result of the row above (items below the first row) and,
// on the last row, the pixel itself for each queued item.
// ============================================================================
module ceod_back import ceod_pkg::*; (
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire logic   head_valid,
	input  wire entry_t head,
	output logic        pop,
	output logic        m_tvalid,
	input  wire logic   m_tready,
	output logic [OUT_TDATA_W-1:0] m_tdata,
	output logic        m_tlast
);

	logic             phase_q;
	logic [31:0]      pix_q;
	logic [AW-1:0]    x_q;
	logic [DIM_W-1:0] y_q;
	logic             load, both, emit, emit_self;

	always_comb begin
		load      = !m_tvalid || m_tready;
		both      = head.has_center && head.has_self;
		emit      = head_valid && (phase_q || head.has_center || head.has_self);
		emit_self = phase_q || !head.has_center;
		pop       = load && head_valid && !(!phase_q && both);
	end

	// output register and phase within the head item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
			phase_q  <= 1'b0;
		end else if (load) begin
			m_tvalid <= emit;
			if (head_valid)
				phase_q <= !phase_q && both;
		end
	end

	always_ff @(posedge clk) begin
		if (load && emit) begin
			if (emit_self) begin
				pix_q   <= head.self_pix;
				y_q     <= head.y;
				m_tlast <= head.last;
			end else begin
				pix_q   <= head.center_pix;
				y_q     <= head.y - DIM_W'(1);
				m_tlast <= 1'b0;
			end
			x_q <= head.x;
		end
	end

	assign m_tdata = {(OUT_TDATA_W-32-AW-DIM_W)'(0), y_q, x_q, pix_q};

endmodule
`default_nettype wire

// ===== hdl/color_edge_outline_darken_top.sv =====
`default_nettype none
// ============================================================================
// color_edge_outline_darken_top - colour edge outline darkening
// Darkens interior pixels on colour edges of a raster frame, one row behind.
// ============================================================================
//  channel | signals                          | transaction
//  --------+----------------------------------+-------------------------------
//  input   | s_tvalid s_tready s_tdata s_tuser| one pixel, tuser = frame start
//  output  | m_tvalid m_tready m_tdata m_tlast| one pixel with position
//  config  | cfg_we cfg_index cfg_data        | one register write per cycle
//
//  One pixel per clock is accepted while s_tready is high; on the last row of a
//  frame each pixel yields two results, so there the output port paces the
//  input. A result passes the line buffer read, the sum stage, a queue slot
//  and the output register before it is offered.
//  Reset clears counters, queue and valid flags; line buffers are not cleared.
//  Input stalls only when four items wait in the pipeline and queue.
module color_edge_outline_darken_top import ceod_pkg::*; (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   s_tvalid,
	output logic                        s_tready,
	input  wire logic [IN_TDATA_W-1:0]  s_tdata,   // [31:0] in_pixel
	input  wire logic                   s_tuser,   // [0] frame_start
	output logic                        m_tvalid,
	input  wire logic                   m_tready,
	output logic [OUT_TDATA_W-1:0]      m_tdata,   // [31:0] out_pixel, [42:32] out_x,
	                                               // [54:43] out_y, [55] zero
	output logic                        m_tlast,
	input  wire logic                   cfg_we,
	input  wire logic [2:0]             cfg_index,
	input  wire logic [DIM_W-1:0]       cfg_data
);

	cfg_t   cfg_q;
	logic   accept, valid_s1, push, pop, head_valid;
	win_t   win_s1;
	ctl_t   ctl_s1;
	entry_t entry, head;
	logic [QAW:0] q_count, occ_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.frame_width    <= DIM_W'(640);
			cfg_q.frame_height   <= DIM_W'(480);
			cfg_q.strength_q8    <= 9'd64;
			cfg_q.edge_threshold <= 11'd72;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_FRAME_WIDTH:    cfg_q.frame_width    <= cfg_data;
				REG_FRAME_HEIGHT:   cfg_q.frame_height   <= cfg_data;
				REG_STRENGTH_Q8:    cfg_q.strength_q8    <= cfg_data[8:0];
				REG_EDGE_THRESHOLD: cfg_q.edge_threshold <= cfg_data[10:0];
				REG_PIXEL_ORDER: begin
					// channel order does not change the result
				end
				default: ;
			endcase
		end
	end

	// items in flight from accept until popped by the back end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			occ_q <= '0;
		else
			occ_q <= occ_q + (QAW+1)'(accept) - (QAW+1)'(pop);
	end

	assign s_tready = occ_q < (QAW+1)'(QDEPTH);
	assign accept   = s_tvalid && s_tready;

	ceod_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.accept     (accept),
		.in_pixel   (s_tdata[31:0]),
		.frame_start(s_tuser),
		.valid_s1   (valid_s1),
		.win_s1     (win_s1),
		.ctl_s1     (ctl_s1)
	);

	ceod_edge u_edge (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg_q),
		.valid_s1(valid_s1),
		.win_s1  (win_s1),
		.ctl_s1  (ctl_s1),
		.push    (push),
		.entry   (entry)
	);

	ceod_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_entry(entry),
		.pop       (pop),
		.head_valid(head_valid),
		.head      (head),
		.count     (q_count)
	);

	ceod_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head_valid(head_valid),
		.head      (head),
		.pop       (pop),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast)
	);

	// credit count covers both pipeline stages and the queue
	a_occ_balance: assert property (@(posedge clk) disable iff (!arst_n)
		occ_q == q_count + (QAW+1)'(valid_s1) + (QAW+1)'(push))
		else $error("in-flight count out of step with pipeline and queue");

	// the queue is never written when full
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> q_count != (QAW+1)'(QDEPTH))
		else $error("queue push while full");

	// nothing is popped from an empty queue
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> head_valid)
		else $error("queue pop while empty");

endmodule
`default_nettype wire
